[rtl/core/frr_pkg.sv]
// Shared types, codes and the CRC-32 byte update for the framed request receiver.
package frr_pkg;

    // Input func codes
    localparam logic [1:0] FUNC_BYTE     = 2'd0;
    localparam logic [1:0] FUNC_GAP      = 2'd1;
    localparam logic [1:0] FUNC_DEADLINE = 2'd2;

    // Result kinds
    localparam logic [2:0] KIND_PAYLOAD = 3'd0;
    localparam logic [2:0] KIND_GOOD    = 3'd1;
    localparam logic [2:0] KIND_BAD_LEN = 3'd2;
    localparam logic [2:0] KIND_BAD_CRC = 3'd3;
    localparam logic [2:0] KIND_ABANDON = 3'd4;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // Sync word "GB5Q", first byte in lane 0
    localparam logic [3:0][7:0] SYNC_WORD = {8'h51, 8'h35, 8'h42, 8'h47};

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  payload_byte;
        logic [14:0] payload_index;
        logic [15:0] frame_length;
        logic        last_flag;
    } out_item_t;

    // Classified item handed from the front to the back
    typedef enum logic [1:0] {
        OP_BYTE,
        OP_GAP,
        OP_DEADLINE
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
        logic [3:0] sync_hit;   // data equals sync byte i
    } token_t;

    // Reflected CRC-32, one byte
    function automatic logic [31:0] crc32_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] x;
        x = c ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
        begin
            x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
        end
        return x;
    endfunction

endpackage

[rtl/core/frr_fifo.sv]
// Small first-word-fall-through queue of fixed-width entries.
module frr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[rtl/core/frr_front.sv]
// Front end: decodes input items into tokens and precomputes sync byte matches.
module frr_front (
    input  logic              push,
    input  frr_pkg::in_item_t rx_item,
    input  logic              cmd_full,
    output logic              cmd_push,
    output frr_pkg::token_t   cmd_token
);
    import frr_pkg::*;

    logic keep;

    always_comb
    begin
        keep          = 1'b1;
        cmd_token.op  = OP_BYTE;
        unique case (rx_item.func)
            FUNC_BYTE:     cmd_token.op = OP_BYTE;
            FUNC_GAP:      cmd_token.op = OP_GAP;
            FUNC_DEADLINE: cmd_token.op = OP_DEADLINE;
            default:       keep = 1'b0;   // unused code: taken and dropped
        endcase
        cmd_token.data = rx_item.data_byte;
        for (int i = 0; i < 4; i++)
        begin
            cmd_token.sync_hit[i] = (rx_item.data_byte == SYNC_WORD[i]);
        end
    end

    assign cmd_push = push && !cmd_full && keep;

endmodule

[rtl/core/frr_back.sv]
// Back end: frame state machine, CRC check and result generation.
module frr_back #(
    parameter int MAX_PAYLOAD = 16392
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  frr_pkg::token_t    cmd_token,
    output logic               cmd_pop,
    input  logic               res_full,
    output logic               res_push,
    output frr_pkg::out_item_t res_item
);
    import frr_pkg::*;

    typedef enum logic [2:0] {
        ST_HUNT,
        ST_LEN_HI,
        ST_LEN_LO,
        ST_PAYLOAD,
        ST_CRC
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [1:0]  sync_reg, sync_next;
    logic        discard_reg, discard_next;
    logic [15:0] length_reg, length_next;
    logic [14:0] count_reg, count_next;
    logic [31:0] crc_reg, crc_next;
    logic [31:0] rx_crc_reg, rx_crc_next;

    logic [14:0] count_inc;
    logic [31:0] crc_upd;
    logic        verdict;
    logic [2:0]  verdict_kind;
    logic        verdict_discard;

    assign cmd_pop   = cmd_valid && !res_full;
    assign count_inc = count_reg + 1'b1;
    assign crc_upd   = crc32_byte(crc_reg, cmd_token.data);

    always_comb
    begin
        phase_next      = phase_reg;
        sync_next       = sync_reg;
        discard_next    = discard_reg;
        length_next     = length_reg;
        count_next      = count_reg;
        crc_next        = crc_reg;
        rx_crc_next     = rx_crc_reg;
        verdict         = 1'b0;
        verdict_kind    = KIND_GOOD;
        verdict_discard = 1'b0;
        res_push        = 1'b0;
        res_item        = '0;

        if (cmd_pop)
        begin
            if (phase_reg == ST_HUNT)
            begin
                if (cmd_token.op == OP_GAP)
                begin
                    sync_next    = '0;
                    discard_next = 1'b0;
                end
                else if (cmd_token.op == OP_BYTE && !discard_reg)
                begin
                    if (!cmd_token.sync_hit[sync_reg])
                    begin
                        sync_next    = '0;
                        discard_next = 1'b1;
                    end
                    else
                    begin
                        sync_next = sync_reg + 1'b1;
                        if (sync_reg == 2'd3)
                        begin
                            phase_next  = ST_LEN_HI;
                            length_next = '0;
                            count_next  = '0;
                            crc_next    = CRC_INIT;
                            rx_crc_next = '0;
                        end
                    end
                end
            end
            else if (cmd_token.op == OP_DEADLINE)
            begin
                verdict         = 1'b1;
                verdict_kind    = KIND_ABANDON;
                verdict_discard = 1'b1;
            end
            else if (cmd_token.op == OP_BYTE)
            begin
                unique case (phase_reg)
                    ST_LEN_HI:
                    begin
                        crc_next    = crc_upd;
                        length_next = {cmd_token.data, 8'd0};
                        phase_next  = ST_LEN_LO;
                    end
                    ST_LEN_LO:
                    begin
                        crc_next    = crc_upd;
                        length_next = {length_reg[15:8], cmd_token.data};
                        if (length_next == '0 || length_next > 16'(MAX_PAYLOAD))
                        begin
                            verdict         = 1'b1;
                            verdict_kind    = KIND_BAD_LEN;
                            verdict_discard = 1'b1;
                        end
                        else
                        begin
                            phase_next = ST_PAYLOAD;
                            count_next = '0;
                        end
                    end
                    ST_PAYLOAD:
                    begin
                        res_push               = 1'b1;
                        res_item.kind          = KIND_PAYLOAD;
                        res_item.payload_byte  = cmd_token.data;
                        res_item.payload_index = count_reg;
                        res_item.frame_length  = length_reg;
                        crc_next               = crc_upd;
                        count_next             = count_inc;
                        if ({1'b0, count_inc} >= length_reg)
                        begin
                            phase_next = ST_CRC;
                            count_next = '0;
                        end
                    end
                    ST_CRC:
                    begin
                        rx_crc_next = rx_crc_reg
                                    | ({24'd0, cmd_token.data} << {count_reg[1:0], 3'b000});
                        count_next  = count_inc;
                        if (count_reg[1:0] == 2'd3)
                        begin
                            verdict = 1'b1;
                            if ((crc_reg ^ CRC_INIT) == rx_crc_next)
                            begin
                                verdict_kind    = KIND_GOOD;
                                verdict_discard = 1'b0;
                            end
                            else
                            begin
                                verdict_kind    = KIND_BAD_CRC;
                                verdict_discard = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        phase_next = ST_HUNT;
                        sync_next  = '0;
                    end
                endcase
            end

            if (verdict)
            begin
                res_push              = 1'b1;
                res_item.kind         = verdict_kind;
                res_item.frame_length = length_next;
                res_item.last_flag    = 1'b1;
                phase_next            = ST_HUNT;
                sync_next             = '0;
                count_next            = '0;
                discard_next          = verdict_discard;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= ST_HUNT;
            sync_reg    <= '0;
            discard_reg <= 1'b0;
            length_reg  <= '0;
            count_reg   <= '0;
            crc_reg     <= CRC_INIT;
            rx_crc_reg  <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            sync_reg    <= sync_next;
            discard_reg <= discard_next;
            length_reg  <= length_next;
            count_reg   <= count_next;
            crc_reg     <= crc_next;
            rx_crc_reg  <= rx_crc_next;
        end
    end

endmodule

[rtl/core/framed_request_receiver.sv]
// Top level of the framed request receiver: front decoder, command queue, deframer, result queue.
//
// Takes one item per cycle unless full: a received byte, an idle gap or a frame deadline. Frames
// are "GB5Q", a big-endian 16-bit length, the payload and a little-endian CRC-32 over
// the length and payload. Each payload byte comes out as a result item as it arrives,
// and each frame attempt ends in one verdict item (good, bad length, bad CRC or
// abandoned) with last_flag set. Sustained rate is one item per cycle in and out while the
// result queue has room; the deframer state machine retires one item per cycle with the
// per-byte CRC update done combinationally. An accepted item goes into the command queue,
// then through the deframer into the result queue, whose head is on the result ports. full
// follows the command queue (CMD_DEPTH items); the deframer stalls only while the result
// queue (RES_DEPTH items) is full, so a slow reader backs up into full after both fill.
// Func code 3 is accepted and dropped at the front.
module framed_request_receiver #(
    parameter int MAX_PAYLOAD = 16392,
    parameter int CMD_DEPTH   = 4,
    parameter int RES_DEPTH   = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  frr_pkg::in_item_t  rx_item,
    output logic               full,
    output logic               empty,
    input  logic               pop,
    output frr_pkg::out_item_t result
);
    import frr_pkg::*;

    logic      cmd_push, cmd_full, cmd_empty, cmd_pop;
    token_t    cmd_wtoken, cmd_rtoken;
    logic      res_push, res_full;
    out_item_t res_item;

    assign full = cmd_full;

    // Front: decode and sync byte compare
    frr_front u_front (
        .push      (push),
        .rx_item   (rx_item),
        .cmd_full  (cmd_full),
        .cmd_push  (cmd_push),
        .cmd_token (cmd_wtoken)
    );

    // Decouples the input side from the deframer
    frr_fifo #(
        .WIDTH ($bits(token_t)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .wdata (cmd_wtoken),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .rdata (cmd_rtoken),
        .empty (cmd_empty)
    );

    // Back: frame state, CRC, verdicts
    frr_back #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (!cmd_empty),
        .cmd_token (cmd_rtoken),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_item  (res_item)
    );

    // Result queue; head is on the result ports
    frr_fifo #(
        .WIDTH ($bits(out_item_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_item),
        .full  (res_full),
        .pop   (pop),
        .rdata (result),
        .empty (empty)
    );

    // The deframer only produces while the result queue has room
    a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result produced into a full queue");

    // Verdicts carry last_flag and no payload data
    a_verdict_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res_item.kind != KIND_PAYLOAD) |->
            (res_item.last_flag && res_item.payload_byte == '0 &&
             res_item.payload_index == '0))
        else $error("malformed verdict item");

    // Payload bytes sit inside the announced length
    a_payload_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res_item.kind == KIND_PAYLOAD) |->
            (!res_item.last_flag && {1'b0, res_item.payload_index} < res_item.frame_length))
        else $error("payload index beyond frame length");

    // A command leaves the queue only when there is one
    a_cmd_pop: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> !cmd_empty)
        else $error("command popped from empty queue");

endmodule

[tb/tb_framed_request_receiver.sv]
// Self-checking testbench for the framed request receiver: frame stimulus, deframing predictor, result checks.
module tb_framed_request_receiver;
    timeunit 1ns;
    timeprecision 1ps;

    import frr_pkg::*;

    // Same value as the block's default; the instance below keeps that default
    localparam int MAX_PAYLOAD = 16392;

    // func code 3 has no name in the package; the block takes it and drops it
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // Longest receiver hold-off used for back-pressure, in cycles
    localparam int READER_HOLD_CYCLES = 60;
    // Cycles with no accepted item on either side before the run is called hung
    localparam int WATCHDOG_LIMIT = 2000;
    // Quiet time after the last expected result, to catch stray results
    localparam int DRAIN_CYCLES = 16;
    // Rough random item count per idling phase (four phases)
    localparam int ITEMS_PER_PHASE = 115;

    // Deframer position, as the predictor tracks it
    typedef enum logic [2:0] {
        ST_HUNT,
        ST_LEN_HI,
        ST_LEN_LO,
        ST_PAYLOAD,
        ST_CRC
    } rx_state_t;

    // How a generated frame goes wrong, if at all
    typedef enum logic [1:0] {
        FAULT_NONE,
        FAULT_CRC,
        FAULT_DEADLINE
    } frame_fault_t;

    // One pending item plus the idling profile it is sent under
    typedef struct {
        in_item_t    item;
        int unsigned sender_idle;
        int unsigned receiver_stall;
        bit          hold_reader;   // start a long reader hold-off when this item goes out
    } stream_entry_t;

    // Idling profile per phase: none, sender only, receiver only, both lightly
    localparam int unsigned SENDER_IDLE_PCT[4]    = '{0, 53, 0, 10};
    localparam int unsigned RECEIVER_STALL_PCT[4] = '{0, 0, 53, 10};

    // ------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------
    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    in_item_t   rx_item = '0;
    logic       full;
    logic       empty;
    logic       pop = 1'b0;
    out_item_t  result;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Reset held once, at the start, then released
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    framed_request_receiver dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .rx_item (rx_item),
        .full    (full),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

    // ------------------------------------------------------------------
    // Stimulus and expectation stores
    // ------------------------------------------------------------------
    stream_entry_t byte_stream[$];       // items waiting to be offered
    out_item_t     awaited_results[$];   // predicted results, oldest first
    int            mismatches = 0;
    int            stim_count = 0;

    // Profile stamped onto items as they are queued
    int unsigned gen_sender_idle = 0;
    int unsigned gen_receiver_stall = 0;
    bit          gen_hold = 1'b0;

    // Receiver stall rate, taken from the item most recently offered
    int unsigned stall_pct = 0;
    // Hold-off handshake between driver (requests) and reader (serves)
    int          hold_requests = 0;
    int          holds_served = 0;
    int          hold_left = 0;

    // ------------------------------------------------------------------
    // Deframing predictor state
    // ------------------------------------------------------------------
    rx_state_t   pred_state = ST_HUNT;
    logic [1:0]  pred_sync_hits = '0;
    logic        pred_discard = 1'b0;
    logic [15:0] pred_length = '0;
    logic [14:0] pred_count = '0;
    logic [31:0] pred_crc = CRC_INIT;
    logic [31:0] pred_rx_crc = '0;

    // Reflected CRC-32 over one byte, bit at a time
    function automatic logic [31:0] crc_next(logic [31:0] crc, logic [7:0] data);
        logic [31:0] acc;
        acc = crc ^ {24'd0, data};
        repeat (8)
        begin
            acc = (acc >> 1) ^ (CRC_POLY & {32{acc[0]}});
        end
        return acc;
    endfunction

    // Record one expected result; verdicts also drop back to hunting
    task automatic expect_result(logic [2:0] kind, logic [7:0] data, logic [14:0] index,
                                 logic verdict, logic enter_discard);
        out_item_t r;
        r.kind          = kind;
        r.payload_byte  = data;
        r.payload_index = index;
        r.frame_length  = pred_length;
        r.last_flag     = verdict;
        awaited_results.push_back(r);
        if (verdict)
        begin
            pred_state     = ST_HUNT;
            pred_sync_hits = '0;
            pred_count     = '0;
            pred_discard   = enter_discard;
        end
    endtask

    // Advance the predictor by one accepted item
    task automatic deframe_item(in_item_t it);
        logic [7:0] b;
        b = it.data_byte;
        if (it.func == FUNC_UNUSED)
            return;

        if (pred_state == ST_HUNT)
        begin
            // A gap re-arms the sync search and ends discard
            if (it.func == FUNC_GAP)
            begin
                pred_sync_hits = '0;
                pred_discard   = 1'b0;
                return;
            end
            if (it.func == FUNC_DEADLINE || pred_discard)
                return;
            // A wrong byte is not retried as a new sync start
            if (b != SYNC_WORD[pred_sync_hits])
            begin
                pred_sync_hits = '0;
                pred_discard   = 1'b1;
                return;
            end
            pred_sync_hits = pred_sync_hits + 2'd1;
            if (pred_sync_hits == 2'd0)
            begin
                pred_state  = ST_LEN_HI;
                pred_length = '0;
                pred_count  = '0;
                pred_crc    = CRC_INIT;
                pred_rx_crc = '0;
            end
            return;
        end

        // Inside a frame gaps are ignored; only the deadline cuts it short
        if (it.func == FUNC_GAP)
            return;
        if (it.func == FUNC_DEADLINE)
        begin
            expect_result(KIND_ABANDON, 8'd0, 15'd0, 1'b1, 1'b1);
            return;
        end

        case (pred_state)
            ST_LEN_HI:
            begin
                pred_crc    = crc_next(pred_crc, b);
                pred_length = {b, 8'd0};
                pred_state  = ST_LEN_LO;
            end
            ST_LEN_LO:
            begin
                pred_crc    = crc_next(pred_crc, b);
                pred_length = {pred_length[15:8], b};
                if (pred_length == 16'd0 || pred_length > MAX_PAYLOAD)
                    expect_result(KIND_BAD_LEN, 8'd0, 15'd0, 1'b1, 1'b1);
                else
                begin
                    pred_state = ST_PAYLOAD;
                    pred_count = '0;
                end
            end
            ST_PAYLOAD:
            begin
                expect_result(KIND_PAYLOAD, b, pred_count, 1'b0, 1'b0);
                pred_crc   = crc_next(pred_crc, b);
                pred_count = pred_count + 15'd1;
                if ({1'b0, pred_count} >= pred_length)
                begin
                    pred_state = ST_CRC;
                    pred_count = '0;
                end
            end
            ST_CRC:
            begin
                // CRC arrives little-endian
                pred_rx_crc = pred_rx_crc | ({24'd0, b} << (8 * pred_count[1:0]));
                pred_count  = pred_count + 15'd1;
                if (pred_count >= 15'd4)
                begin
                    if ((pred_crc ^ CRC_INIT) == pred_rx_crc)
                        expect_result(KIND_GOOD, 8'd0, 15'd0, 1'b1, 1'b0);
                    else
                        expect_result(KIND_BAD_CRC, 8'd0, 15'd0, 1'b1, 1'b1);
                end
            end
            default:
            begin
                pred_state     = ST_HUNT;
                pred_sync_hits = '0;
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    task automatic queue_item(logic [1:0] func, logic [7:0] data);
        stream_entry_t e;
        e.item.func      = func;
        e.item.data_byte = data;
        e.sender_idle    = gen_sender_idle;
        e.receiver_stall = gen_receiver_stall;
        e.hold_reader    = gen_hold;
        gen_hold = 1'b0;
        byte_stream.push_back(e);
        stim_count++;
    endtask

    task automatic queue_gap();
        queue_item(FUNC_GAP, 8'($urandom));
    endtask

    // First n bytes of the sync word
    task automatic queue_sync(int n);
        for (int k = 0; k < n; k++)
            queue_item(FUNC_BYTE, SYNC_WORD[k]);
    endtask

    task automatic queue_bad_length(logic [15:0] len);
        queue_sync(4);
        queue_item(FUNC_BYTE, len[15:8]);
        queue_item(FUNC_BYTE, len[7:0]);
    endtask

    // Complete frame with random payload; optional fault and stray gaps inside
    task automatic queue_frame(logic [15:0] len, frame_fault_t fault, int unsigned gap_pct);
        logic [7:0]  frame_bytes[$];
        logic [7:0]  data;
        logic [31:0] crc;
        int          cut;
        int          idx;
        for (int k = 0; k < 4; k++)
            frame_bytes.push_back(SYNC_WORD[k]);
        frame_bytes.push_back(len[15:8]);
        frame_bytes.push_back(len[7:0]);
        crc = crc_next(CRC_INIT, len[15:8]);
        crc = crc_next(crc, len[7:0]);
        for (int k = 0; k < len; k++)
        begin
            data = 8'($urandom);
            frame_bytes.push_back(data);
            crc = crc_next(crc, data);
        end
        crc = crc ^ CRC_INIT;
        for (int k = 0; k < 4; k++)
            frame_bytes.push_back(crc[8*k +: 8]);

        if (fault == FAULT_CRC)
        begin
            idx = frame_bytes.size() - 1 - $urandom_range(3, 0);
            frame_bytes[idx] = frame_bytes[idx] ^ 8'($urandom_range(255, 1));
        end

        // A deadline cut always lands after the sync word, so a frame is open
        cut = (fault == FAULT_DEADLINE) ? $urandom_range(frame_bytes.size() - 1, 4)
                                        : frame_bytes.size();
        for (int k = 0; k < cut; k++)
        begin
            if (k >= 4 && $urandom_range(99, 0) < gap_pct)
                queue_gap();
            queue_item(FUNC_BYTE, frame_bytes[k]);
        end
        if (fault == FAULT_DEADLINE)
            queue_item(FUNC_DEADLINE, 8'($urandom));
    endtask

    // One random sequence: mostly real frames, some broken ones and noise
    task automatic queue_random_sequence();
        int unsigned  pick;
        int unsigned  roll;
        int           n;
        frame_fault_t fault;
        logic [15:0]  len;
        pick = $urandom_range(99, 0);
        if (pick < 62)
        begin
            len  = ($urandom_range(99, 0) < 85) ? 16'($urandom_range(12, 1))
                                                : 16'($urandom_range(80, 13));
            roll = $urandom_range(99, 0);
            fault = (roll < 75) ? FAULT_NONE : (roll < 88) ? FAULT_CRC : FAULT_DEADLINE;
            queue_frame(len, fault, 5);
            // Good frames may run back to back; a failed one needs a gap to resync
            if (fault != FAULT_NONE || $urandom_range(99, 0) < 30)
                queue_gap();
        end
        else if (pick < 72)
        begin
            len = $urandom_range(1, 0) ? 16'd0 : 16'($urandom_range(65535, MAX_PAYLOAD + 1));
            queue_bad_length(len);
            queue_gap();
        end
        else if (pick < 81)
        begin
            // Sync broken part way, then bytes that discard swallows
            n = $urandom_range(3, 0);
            queue_sync(n);
            queue_item(FUNC_BYTE, SYNC_WORD[n] ^ 8'($urandom_range(255, 1)));
            repeat ($urandom_range(2, 0))
                queue_item(FUNC_BYTE, 8'($urandom));
            queue_gap();
        end
        else if (pick < 88)
        begin
            // Partial sync abandoned by a gap
            queue_sync($urandom_range(3, 1));
            queue_gap();
        end
        else
        begin
            repeat ($urandom_range(6, 1))
                queue_item(2'($urandom_range(3, 0)), 8'($urandom));
            queue_gap();
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: offers pending items; predicts each one the block accepts
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : driver
        stream_entry_t e;
        if (!rst_n)
            push <= 1'b0;
        else
        begin
            if (push && !full)
                deframe_item(rx_item);
            // Hold the current item while the block is full
            if (!push || !full)
            begin
                if (byte_stream.size() != 0
                    && $urandom_range(99, 0) >= byte_stream[0].sender_idle)
                begin
                    e = byte_stream.pop_front();
                    push      <= 1'b1;
                    rx_item   <= e.item;
                    stall_pct <= e.receiver_stall;
                    if (e.hold_reader)
                        hold_requests <= hold_requests + 1;
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: takes results and compares them with the oldest prediction
    // ------------------------------------------------------------------
    function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin : monitor
        out_item_t want;
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("unexpected result: kind 0x%0h, payload_byte 0x%0h",
                           result.kind, result.payload_byte);
                    mismatches++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("kind", 32'(want.kind), 32'(result.kind));
                    check_field("payload_byte", 32'(want.payload_byte),
                                32'(result.payload_byte));
                    check_field("payload_index", 32'(want.payload_index),
                                32'(result.payload_index));
                    check_field("frame_length", 32'(want.frame_length),
                                32'(result.frame_length));
                    check_field("last_flag", 32'(want.last_flag), 32'(result.last_flag));
                end
            end

            // A long hold-off lets the block fill and push back on the sender
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                pop <= 1'b0;
            end
            else if (holds_served != hold_requests)
            begin
                holds_served++;
                hold_left = READER_HOLD_CYCLES - 1;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(99, 0) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: no item moving on either side for too long means a hang
    // ------------------------------------------------------------------
    initial
    begin : watchdog
        int stalled_cycles;
        stalled_cycles = 0;
        while (stalled_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (push && !full) || (pop && !empty))
                stalled_cycles = 0;
            else
                stalled_cycles++;
        end
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin : sequencer
        int target;

        // Directed part: every func code, each special case, the length limits
        queue_item(FUNC_DEADLINE, 8'hFF);       // deadline while hunting: ignored
        queue_item(FUNC_UNUSED, 8'hA5);         // unused code: dropped
        queue_gap();
        queue_item(FUNC_BYTE, SYNC_WORD[0]);
        queue_item(FUNC_BYTE, 8'h00);           // sync mismatch enters discard
        queue_item(FUNC_BYTE, SYNC_WORD[0]);    // swallowed by discard
        queue_gap();                            // gap ends discard
        queue_bad_length(16'd0);                // zero length
        queue_gap();
        queue_bad_length(16'(MAX_PAYLOAD + 1)); // one past the limit
        queue_gap();
        queue_frame(16'd1, FAULT_NONE, 0);      // shortest good frame
        queue_sync(4);
        queue_item(FUNC_BYTE, 8'h12);
        queue_item(FUNC_DEADLINE, 8'h00);       // abandoned with half a length
        queue_gap();

        // Random part in four idling phases
        for (int p = 0; p < 4; p++)
        begin
            gen_sender_idle    = SENDER_IDLE_PCT[p];
            gen_receiver_stall = RECEIVER_STALL_PCT[p];
            if (p == 0)
            begin
                // Mid-sized frame sent flat out; the reader holds off at its
                // start so the block backs up into full
                gen_hold = 1'b1;
                queue_frame(16'd24, FAULT_NONE, 0);
                queue_gap();
            end
            target = stim_count + ITEMS_PER_PHASE;
            while (stim_count < target)
                queue_random_sequence();
        end

        // Wait until every item is in and every prediction has come back
        while (byte_stream.size() != 0 || push)
            @(posedge clk);
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/frr_pkg.sv
rtl/core/frr_fifo.sv
rtl/core/frr_front.sv
rtl/core/frr_back.sv
rtl/core/framed_request_receiver.sv
tb/tb_framed_request_receiver.sv
